// ----- src/posting_skip_to_search_unit_assert.svh -----
// assertion macros for the posting skip-to search unit
`ifndef POSTING_SKIP_TO_SEARCH_UNIT_ASSERT_SVH
`define POSTING_SKIP_TO_SEARCH_UNIT_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define PSS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pss assertion failed");
// next-cycle implication
`define PSS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pss assertion failed");
`else
`define PSS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PSS_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- src/pss_pkg.sv -----
// shared types and constants for the posting skip-to search unit
package pss_pkg;

    localparam int unsigned BUFFER_DEPTH = 256;
    localparam int IDX_W = $clog2(BUFFER_DEPTH);
    localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
    localparam int ID_W = 32;
    localparam int STATUS_W = 2;
    localparam int S_TDATA_W = ((2 * ID_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((ID_W + CNT_W + 7) / 8) * 8;

    typedef enum logic [STATUS_W-1:0] {
        ST_FOUND     = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_LOADED    = 2'd2
    } t_status;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_SKIP = 1'b1
    } t_op;

    typedef struct packed {
        logic [ID_W-1:0]  found_id;
        t_status          status;
        logic [CNT_W-1:0] cursor_pos;
    } t_result;

    typedef struct packed {
        logic [ID_W-1:0] diff;
        logic            lt;
        logic            eq;
    } t_alu_res;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        logic [ID_W-1:0]  data;
    } t_mem_wr;

endpackage

// ----- src/posting_skip_to_search_unit.sv -----
// top level: stream ports, output register and search sequencer
//
//  channel | dir | tdata                               | tuser       | tlast
//  s_axis  | in  | [31:0] load_id, [63:32] target      | [0] op      | load_last
//  m_axis  | out | [31:0] found_id, [40:32] cursor_pos | [1:0] status| -
//
// sequence per word: a load stores the id and reports loaded; a skip on a used-up buffer
//   reports exhausted; a skip with target at or below the current id returns the current entry;
//   other skips clamp a window and binary-search it, paced by the single read port and shared compare
// s_axis_tready is high only while the sequencer is idle, one word at a time
// reset clears cursor, fill count and load pointer; buffer contents are not cleared
// a stalled m_axis holds the next result in the sequencer until the output register frees
module posting_skip_to_search_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [pss_pkg::S_TDATA_W-1:0]  s_axis_tdata,  // load_id, target
    input  logic                           s_axis_tuser,  // op
    input  logic                           s_axis_tlast,  // load_last
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [pss_pkg::M_TDATA_W-1:0]  m_axis_tdata,  // found_id, cursor_pos, zero pad
    output logic [pss_pkg::STATUS_W-1:0]   m_axis_tuser   // status
);
    import pss_pkg::*;

    logic    w_idle, w_start, w_res_valid, w_res_ready;
    t_result w_res;
    t_op     w_op;
    logic    r_m_valid;
    t_result r_m_res;

    assign w_op    = t_op'(s_axis_tuser);
    assign w_start = s_axis_tvalid && w_idle;

    pss_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_op        (w_op),
        .i_load_id   (s_axis_tdata[ID_W-1:0]),
        .i_load_last (s_axis_tlast),
        .i_target    (s_axis_tdata[2*ID_W-1:ID_W]),
        .i_res_ready (w_res_ready),
        .o_idle      (w_idle),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    // output register takes a word when empty or being drained
    assign w_res_ready = !r_m_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_res_valid && w_res_ready) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_ready) begin
            r_m_res <= w_res;
        end
    end

    assign s_axis_tready = w_idle;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = M_TDATA_W'({r_m_res.cursor_pos, r_m_res.found_id});
    assign m_axis_tuser  = r_m_res.status;

endmodule

// ----- src/pss_id_ram.sv -----
// document id buffer: one write port, one registered read port
module pss_id_ram (
    input  logic                       i_clk,
    input  pss_pkg::t_mem_wr           i_wr,
    input  logic [pss_pkg::IDX_W-1:0]  i_raddr,
    output logic [pss_pkg::ID_W-1:0]   o_rdata
);
    import pss_pkg::*;

    logic [ID_W-1:0] r_mem [BUFFER_DEPTH];
    logic [ID_W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // read port, registered: data appears in the cycle after the address
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/pss_alu.sv -----
// shared subtract and compare unit
module pss_alu (
    input  logic [pss_pkg::ID_W-1:0] i_a,
    input  logic [pss_pkg::ID_W-1:0] i_b,
    output pss_pkg::t_alu_res        o_res
);
    import pss_pkg::*;

    logic [ID_W:0] w_sub;

    // borrow of a - b gives a < b
    assign w_sub      = {1'b0, i_a} - {1'b0, i_b};
    assign o_res.diff = w_sub[ID_W-1:0];
    assign o_res.lt   = w_sub[ID_W];
    assign o_res.eq   = (i_a == i_b);

endmodule

// ----- src/pss_seq.sv -----
// sequencer: load handling and windowed binary search over the id buffer
`include "posting_skip_to_search_unit_assert.svh"
module pss_seq (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  pss_pkg::t_op               i_op,
    input  logic [pss_pkg::ID_W-1:0]   i_load_id,
    input  logic                       i_load_last,
    input  logic [pss_pkg::ID_W-1:0]   i_target,
    input  logic                       i_res_ready,
    output logic                       o_idle,
    output logic                       o_res_valid,
    output pss_pkg::t_result           o_res
);
    import pss_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE    = 12'b0000_0000_0001,
        S_CMP_CUR = 12'b0000_0000_0010,
        S_WIN     = 12'b0000_0000_0100,
        S_RD_HI   = 12'b0000_0000_1000,
        S_CMP_HI  = 12'b0000_0001_0000,
        S_RD_MID  = 12'b0000_0010_0000,
        S_CMP_MID = 12'b0000_0100_0000,
        S_RD_LO   = 12'b0000_1000_0000,
        S_CMP_LO  = 12'b0001_0000_0000,
        S_FIN     = 12'b0010_0000_0000,
        S_DONE    = 12'b0100_0000_0000,
        S_SPARE   = 12'b1000_0000_0000
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cursor, n_cursor;
    logic [CNT_W-1:0] r_fill, n_fill;
    logic [CNT_W-1:0] r_lp, n_lp;

    logic [ID_W-1:0]  r_target, n_target;
    logic [ID_W-1:0]  r_diff, n_diff;
    logic [CNT_W-1:0] r_lo, n_lo;
    logic [CNT_W-1:0] r_hi_p1, n_hi_p1;
    logic [CNT_W-1:0] r_mid, n_mid;
    logic [ID_W-1:0]  r_hit, n_hit;
    logic [CNT_W-1:0] r_pick, n_pick;
    t_result          r_res, n_res;

    logic [ID_W-1:0]  w_alu_a, w_alu_b;
    t_alu_res         w_alu;
    logic [ID_W-1:0]  w_rdata;
    logic [IDX_W-1:0] w_raddr;
    t_mem_wr          w_wr;

    logic [CNT_W-1:0] w_span, w_mid, w_hi_idx, w_room, w_end, w_mid_p1, w_fill_m1;
    logic             w_lp_room;

    // buffer and shared compare unit
    pss_id_ram u_ram (
        .i_clk   (i_clk),
        .i_wr    (w_wr),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    pss_alu u_alu (
        .i_a   (w_alu_a),
        .i_b   (w_alu_b),
        .o_res (w_alu)
    );

    // index arithmetic
    assign w_span    = r_hi_p1 - r_lo - CNT_W'(1);
    assign w_mid     = r_lo + (w_span >> 1);
    assign w_hi_idx  = r_hi_p1 - CNT_W'(1);
    assign w_fill_m1 = r_fill - CNT_W'(1);
    assign w_room    = w_fill_m1 - r_cursor;
    assign w_end     = r_cursor + r_diff[CNT_W-1:0];
    assign w_mid_p1  = r_mid + CNT_W'(1);
    assign w_lp_room = (r_lp < CNT_W'(BUFFER_DEPTH));

    // read address select
    always_comb begin
        unique case (r_state)
            S_RD_HI:  w_raddr = w_hi_idx[IDX_W-1:0];
            S_RD_MID: w_raddr = w_mid[IDX_W-1:0];
            S_RD_LO:  w_raddr = r_lo[IDX_W-1:0];
            default:  w_raddr = r_cursor[IDX_W-1:0];
        endcase
    end

    // compare unit operand select
    always_comb begin
        unique case (r_state)
            S_WIN: begin
                w_alu_a = r_diff;
                w_alu_b = ID_W'(w_room);
            end
            S_FIN: begin
                w_alu_a = r_hit;
                w_alu_b = r_target;
            end
            default: begin
                w_alu_a = r_target;
                w_alu_b = w_rdata;
            end
        endcase
    end

    // buffer write on load
    always_comb begin
        w_wr.en   = i_start && (i_op == OP_LOAD) && w_lp_room && (r_state == S_IDLE);
        w_wr.addr = r_lp[IDX_W-1:0];
        w_wr.data = i_load_id;
    end

    // next state
    always_comb begin
        n_state  = r_state;
        n_cursor = r_cursor;
        n_fill   = r_fill;
        n_lp     = r_lp;
        n_target = r_target;
        n_diff   = r_diff;
        n_lo     = r_lo;
        n_hi_p1  = r_hi_p1;
        n_mid    = r_mid;
        n_hit    = r_hit;
        n_pick   = r_pick;
        n_res    = r_res;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_target = i_target;
                    if (i_op == OP_LOAD) begin
                        n_lp = w_lp_room ? (r_lp + CNT_W'(1)) : r_lp;
                        n_res.found_id   = '0;
                        n_res.status     = ST_LOADED;
                        n_res.cursor_pos = r_cursor;
                        if (i_load_last) begin
                            n_fill           = n_lp;
                            n_cursor         = '0;
                            n_lp             = '0;
                            n_res.cursor_pos = '0;
                        end
                        n_state = S_DONE;
                    end else if (r_cursor >= r_fill) begin
                        n_res.found_id   = '0;
                        n_res.status     = ST_EXHAUSTED;
                        n_res.cursor_pos = r_cursor;
                        n_state          = S_DONE;
                    end else begin
                        n_state = S_CMP_CUR;
                    end
                end
            end
            S_CMP_CUR: begin
                if (w_alu.eq || w_alu.lt) begin
                    n_res.found_id   = w_rdata;
                    n_res.status     = ST_FOUND;
                    n_res.cursor_pos = r_cursor;
                    n_state          = S_DONE;
                end else begin
                    n_diff  = w_alu.diff;
                    n_state = S_WIN;
                end
            end
            S_WIN: begin
                // clamp window end to the last filled entry
                n_hi_p1 = (!w_alu.lt && !w_alu.eq) ? r_fill : (w_end + CNT_W'(1));
                n_lo    = r_cursor;
                n_state = S_RD_HI;
            end
            S_RD_HI: begin
                n_state = S_CMP_HI;
            end
            S_CMP_HI: begin
                n_hit   = w_rdata;
                n_pick  = w_hi_idx;
                n_state = S_RD_MID;
            end
            S_RD_MID: begin
                n_mid   = w_mid;
                n_state = S_CMP_MID;
            end
            S_CMP_MID: begin
                if (w_alu.eq) begin
                    n_hit   = r_target;
                    n_pick  = r_mid;
                    n_state = S_FIN;
                end else if (w_alu.lt) begin
                    n_hi_p1 = r_mid;
                    n_hit   = w_rdata;
                    n_pick  = r_mid;
                    n_state = (r_lo < r_mid) ? S_RD_MID : S_FIN;
                end else begin
                    n_lo    = w_mid_p1;
                    n_state = (w_mid_p1 < r_hi_p1) ? S_RD_LO : S_FIN;
                end
            end
            S_RD_LO: begin
                n_state = S_CMP_LO;
            end
            S_CMP_LO: begin
                // entry just above the probe already passes the key
                if (w_alu.lt) begin
                    n_hit  = w_rdata;
                    n_pick = r_lo;
                end
                n_state = S_RD_MID;
            end
            S_FIN: begin
                if (!w_alu.lt) begin
                    n_cursor         = r_pick;
                    n_res.found_id   = r_hit;
                    n_res.status     = ST_FOUND;
                    n_res.cursor_pos = r_pick;
                end else begin
                    n_cursor         = r_fill;
                    n_res.found_id   = '0;
                    n_res.status     = ST_EXHAUSTED;
                    n_res.cursor_pos = r_fill;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cursor <= '0;
            r_fill   <= '0;
            r_lp     <= '0;
        end else begin
            r_state  <= n_state;
            r_cursor <= n_cursor;
            r_fill   <= n_fill;
            r_lp     <= n_lp;
        end
    end

    // search and result registers
    always_ff @(posedge i_clk) begin
        r_target <= n_target;
        r_diff   <= n_diff;
        r_lo     <= n_lo;
        r_hi_p1  <= n_hi_p1;
        r_mid    <= n_mid;
        r_hit    <= n_hit;
        r_pick   <= n_pick;
        r_res    <= n_res;
    end

    assign o_idle      = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

    `PSS_ASSERT_IMP(a_cursor_in_fill, i_clk, i_rst_n, 1'b1, r_cursor <= r_fill)
    `PSS_ASSERT_IMP(a_fill_in_depth, i_clk, i_rst_n, 1'b1, r_fill <= CNT_W'(BUFFER_DEPTH))
    `PSS_ASSERT_IMP(a_probe_in_window, i_clk, i_rst_n, r_state == S_RD_MID, r_lo < r_hi_p1)
    `PSS_ASSERT_NXT(a_start_leaves_idle, i_clk, i_rst_n, o_idle && i_start, !o_idle)
    `PSS_ASSERT_NXT(a_done_holds, i_clk, i_rst_n, o_res_valid && !i_res_ready, o_res_valid)

endmodule
